// ----- rtl/aad_pkg.sv -----
package aad_pkg;

  localparam int unsigned POS_W    = 13;
  localparam int unsigned OPW      = 14;
  localparam int unsigned EDGE_W   = 2 * OPW;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned DCOL_W   = 11;
  localparam int unsigned DROW_W   = 12;
  localparam int unsigned TW_W     = 12;
  localparam int unsigned LANES    = 3;
  localparam int unsigned DIV_CNT_W = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd3;

  localparam logic [DCOL_W-1:0] DCOL_MAX = '1;
  localparam logic [DROW_W-1:0] DROW_MAX = '1;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic             frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]  red_out;
    logic [PIX_W-1:0]  green_out;
    logic [PIX_W-1:0]  blue_out;
    logic [DCOL_W-1:0] out_column;
    logic [DROW_W-1:0] out_row;
    logic              frame_end;
  } pix_out_t;

  typedef enum logic [1:0] {
    OP_COL,
    OP_ROW,
    OP_AREA
  } op_sel_e;

  typedef logic [LANES-1:0][SUM_W-1:0] lanes_t;

  typedef struct packed {
    logic    accept;
    logic    clr_en;
    logic    start_pos;
    logic    mul_en;
    logic    div_start;
    op_sel_e op_sel;
    logic    col_edge_ld;
    logic    row_edge_ld;
    logic    rd_en;
    logic    acc_en;
    logic    out_ld;
    logic    adv;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic reload_col;
    logic reload_row;
    logic div_done;
    logic emit;
    logic col_adv;
    logic row_adv;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- rtl/aad_divider.sv -----
module aad_divider import aad_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  lanes_t           dividend_i,
  input  logic [SUM_W-1:0] divisor_i,
  output lanes_t           quotient_o,
  output logic             done_o
);

  lanes_t                 quo_q, quo_d;
  lanes_t                 rem_q, rem_d;
  logic [SUM_W-1:0]       div_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic                   busy_q;
  logic                   done_q;
  logic [LANES-1:0][SUM_W:0] trial;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      trial[i] = {rem_q[i], quo_q[i][SUM_W-1]};
      if (trial[i] >= {1'b0, div_q}) begin
        rem_d[i] = SUM_W'(trial[i] - {1'b0, div_q});
        quo_d[i] = {quo_q[i][SUM_W-2:0], 1'b1};
      end else begin
        rem_d[i] = trial[i][SUM_W-1:0];
        quo_d[i] = {quo_q[i][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(SUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("Division started while the divider is still busy.");
`endif

endmodule

// ----- rtl/aad_datapath.sv -----
module aad_datapath import aad_pkg::*; #(
  parameter int unsigned MAX_SOURCE_WIDTH  = 4096,
  parameter int unsigned MAX_SOURCE_HEIGHT = 4096,
  parameter int unsigned MAX_TARGET_WIDTH  = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  pix_in_t               in_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output pix_out_t              out_data_o,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o
);

  localparam int unsigned AW = (MAX_TARGET_WIDTH > 1) ? $clog2(MAX_TARGET_WIDTH) : 1;
  localparam logic [AW-1:0] ClrLast = AW'(MAX_TARGET_WIDTH - 1);
  localparam logic [POS_W:0] MaxSw = (POS_W + 1)'(MAX_SOURCE_WIDTH);
  localparam logic [POS_W:0] MaxSh = (POS_W + 1)'(MAX_SOURCE_HEIGHT);
  localparam logic [POS_W:0] MaxTw = (POS_W + 1)'(MAX_TARGET_WIDTH);
  localparam logic [31:0]    MemDepth = 32'(MAX_TARGET_WIDTH);

  logic [POS_W-1:0] cfg_sw_q, cfg_sh_q, cfg_th_q;
  logic [TW_W-1:0]  cfg_tw_q;
  logic [POS_W-1:0] sw_c, sh_c, dw_c, dh_c, wmax_c;
  logic [POS_W-1:0] sw_q, sh_q, dw_q, dh_q;

  pix_in_t           pix_q;
  logic [POS_W-1:0]  src_col_q, src_row_q;
  logic [DCOL_W-1:0] dest_col_q;
  logic [DROW_W-1:0] dest_row_q;
  logic [EDGE_W-1:0] ncol_edge_q, nrow_edge_q, bcol_q, brow_q;
  logic [EDGE_W-1:0] mul_q;
  logic [OPW-1:0]    mul_a, mul_b, w_q, h_q, w_c, h_c;
  logic [OPW-1:0]    col_p1, row_p1;
  logic              row_end_c, frame_last_c, colbox_c, rowbox_c, emit_c;
  logic              re_q, fl_q, colbox_q, rowbox_q, emit_q;

  logic [LANES*SUM_W-1:0] mem [MAX_TARGET_WIDTH];
  logic [LANES*SUM_W-1:0] rdata_q, mem_wd;
  logic [AW-1:0]          clr_q, mem_addr, mem_wa;
  logic                   mem_we, in_mem;
  lanes_t                 sums_new, sums_q;

  lanes_t           div_dividend, div_quo;
  logic [SUM_W-1:0] div_divisor;
  logic             div_done;

  pix_out_t out_q;
  logic     out_valid_q;
  logic [PIX_W-1:0] avg [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sw_q <= POS_W'(1);
      cfg_sh_q <= POS_W'(1);
      cfg_tw_q <= TW_W'(1);
      cfg_th_q <= POS_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SOURCE_WIDTH:  cfg_sw_q <= cfg_data_i;
        CFG_SOURCE_HEIGHT: cfg_sh_q <= cfg_data_i;
        CFG_TARGET_WIDTH:  cfg_tw_q <= cfg_data_i[TW_W-1:0];
        CFG_TARGET_HEIGHT: cfg_th_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_sw_q == '0) sw_c = POS_W'(1);
    else if ({1'b0, cfg_sw_q} > MaxSw) sw_c = MaxSw[POS_W-1:0];
    else sw_c = cfg_sw_q;
    if (cfg_sh_q == '0) sh_c = POS_W'(1);
    else if ({1'b0, cfg_sh_q} > MaxSh) sh_c = MaxSh[POS_W-1:0];
    else sh_c = cfg_sh_q;
    wmax_c = ({1'b0, sw_c} < MaxTw) ? sw_c : MaxTw[POS_W-1:0];
    if (cfg_tw_q == '0) dw_c = POS_W'(1);
    else if (POS_W'(cfg_tw_q) > wmax_c) dw_c = wmax_c;
    else dw_c = POS_W'(cfg_tw_q);
    if (cfg_th_q == '0) dh_c = POS_W'(1);
    else if (cfg_th_q > sh_c) dh_c = sh_c;
    else dh_c = cfg_th_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q <= in_data_i;
      sw_q  <= sw_c;
      sh_q  <= sh_c;
      dw_q  <= dw_c;
      dh_q  <= dh_c;
    end
  end

  assign col_p1       = OPW'(src_col_q) + OPW'(1);
  assign row_p1       = OPW'(src_row_q) + OPW'(1);
  assign row_end_c    = col_p1 >= OPW'(sw_q);
  assign frame_last_c = row_end_c && (row_p1 >= OPW'(sh_q));
  assign colbox_c     = row_end_c || (EDGE_W'(col_p1) >= ncol_edge_q);
  assign rowbox_c     = frame_last_c || (EDGE_W'(row_p1) >= nrow_edge_q);
  assign emit_c       = colbox_c && rowbox_c;
  assign w_c = (EDGE_W'(src_col_q) >= bcol_q) ? col_p1 - bcol_q[OPW-1:0] : OPW'(1);
  assign h_c = (EDGE_W'(src_row_q) >= brow_q) ? row_p1 - brow_q[OPW-1:0] : OPW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q   <= '0;
      src_row_q   <= '0;
      dest_col_q  <= '0;
      dest_row_q  <= '0;
      ncol_edge_q <= '0;
      nrow_edge_q <= '0;
      bcol_q      <= '0;
      brow_q      <= '0;
      re_q        <= 1'b0;
      fl_q        <= 1'b0;
      colbox_q    <= 1'b0;
      rowbox_q    <= 1'b0;
      emit_q      <= 1'b0;
    end else begin
      if (cmd_i.accept && in_data_i.frame_start) begin
        src_col_q <= '0;
        src_row_q <= '0;
      end
      if (cmd_i.start_pos && src_col_q == '0) begin
        dest_col_q <= '0;
        bcol_q     <= '0;
        if (src_row_q == '0) begin
          dest_row_q <= '0;
          brow_q     <= '0;
        end
      end
      if (cmd_i.col_edge_ld) ncol_edge_q <= div_quo[0][EDGE_W-1:0];
      if (cmd_i.row_edge_ld) nrow_edge_q <= div_quo[0][EDGE_W-1:0];
      if (cmd_i.acc_en) begin
        re_q     <= row_end_c;
        fl_q     <= frame_last_c;
        colbox_q <= colbox_c;
        rowbox_q <= rowbox_c;
        emit_q   <= emit_c;
      end
      if (cmd_i.adv) begin
        if (fl_q) begin
          src_col_q <= '0;
          src_row_q <= '0;
        end else if (re_q) begin
          src_col_q <= '0;
          src_row_q <= src_row_q + 1'b1;
          if (rowbox_q) begin
            brow_q <= nrow_edge_q;
            if (dest_row_q != DROW_MAX) dest_row_q <= dest_row_q + 1'b1;
          end
        end else begin
          src_col_q <= src_col_q + 1'b1;
          if (colbox_q) begin
            bcol_q <= ncol_edge_q;
            if (dest_col_q != DCOL_MAX) dest_col_q <= dest_col_q + 1'b1;
          end
        end
      end
    end
  end

  assign in_mem   = 32'(dest_col_q) < MemDepth;
  assign mem_addr = AW'(dest_col_q);

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sums_new[i] = rdata_q[i*SUM_W +: SUM_W];
    end
    sums_new[0] = sums_new[0] + SUM_W'(pix_q.red_in);
    sums_new[1] = sums_new[1] + SUM_W'(pix_q.green_in);
    sums_new[2] = sums_new[2] + SUM_W'(pix_q.blue_in);
  end

  assign mem_we = cmd_i.clr_en || (cmd_i.acc_en && in_mem);
  assign mem_wa = cmd_i.clr_en ? clr_q : mem_addr;
  assign mem_wd = (cmd_i.clr_en || emit_c) ? '0 : sums_new;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd_i.rd_en) rdata_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_q <= (clr_q == ClrLast) ? '0 : clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      sums_q <= in_mem ? sums_new : '0;
      w_q    <= w_c;
      h_q    <= h_c;
    end
    if (cmd_i.mul_en) mul_q <= mul_a * mul_b;
  end

  always_comb begin
    unique case (cmd_i.op_sel)
      OP_COL: begin
        mul_a = OPW'(dest_col_q) + OPW'(1);
        mul_b = OPW'(sw_q);
      end
      OP_ROW: begin
        mul_a = OPW'(dest_row_q) + OPW'(1);
        mul_b = OPW'(sh_q);
      end
      default: begin
        mul_a = w_q;
        mul_b = h_q;
      end
    endcase
  end

  always_comb begin
    div_dividend    = '0;
    div_dividend[0] = SUM_W'(mul_q);
    unique case (cmd_i.op_sel)
      OP_COL:  div_divisor = SUM_W'(dw_q);
      OP_ROW:  div_divisor = SUM_W'(dh_q);
      default: begin
        div_divisor  = SUM_W'(mul_q);
        div_dividend = sums_q;
      end
    endcase
  end

  aad_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      avg[i] = (div_quo[i] > SUM_W'(255)) ? '1 : div_quo[i][PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_q.red_out    <= avg[0];
      out_q.green_out  <= avg[1];
      out_q.blue_out   <= avg[2];
      out_q.out_column <= dest_col_q;
      out_q.out_row    <= dest_row_q;
      out_q.frame_end  <= fl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.clr_last   = clr_q == ClrLast;
  assign status_o.reload_col = src_col_q == '0;
  assign status_o.reload_row = (src_col_q == '0) && (src_row_q == '0);
  assign status_o.div_done   = div_done;
  assign status_o.emit       = emit_q;
  assign status_o.col_adv    = !fl_q && !re_q && colbox_q;
  assign status_o.row_adv    = !fl_q && re_q && rowbox_q;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |-> !(out_valid_q && !out_ready_i))
    else $error("Result loaded over a transaction that has not been taken.");
`endif

endmodule

// ----- rtl/aad_ctrl.sv -----
module aad_ctrl import aad_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_frame_start_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_START,
    S_CMUL, S_CDIV, S_CWAIT,
    S_RMUL, S_RDIV, S_RWAIT,
    S_READ, S_ACC, S_CHK,
    S_AMUL, S_ADIV, S_AWAIT,
    S_EMIT, S_ADV
  } state_e;

  state_e state_q;
  logic   pend_q;
  logic   phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pend_q  <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          if (status_i.clr_last) begin
            state_q <= pend_q ? S_START : S_IDLE;
            pend_q  <= 1'b0;
          end
        end
        S_IDLE: begin
          phase_q <= 1'b0;
          if (in_valid_i) begin
            if (in_frame_start_i) begin
              pend_q  <= 1'b1;
              state_q <= S_CLEAR;
            end else begin
              state_q <= S_START;
            end
          end
        end
        S_START: state_q <= status_i.reload_col ? S_CMUL : S_READ;
        S_CMUL:  state_q <= S_CDIV;
        S_CDIV:  state_q <= S_CWAIT;
        S_CWAIT: begin
          if (status_i.div_done) begin
            if (phase_q) state_q <= S_IDLE;
            else state_q <= status_i.reload_row ? S_RMUL : S_READ;
          end
        end
        S_RMUL:  state_q <= S_RDIV;
        S_RDIV:  state_q <= S_RWAIT;
        S_RWAIT: begin
          if (status_i.div_done) state_q <= phase_q ? S_IDLE : S_READ;
        end
        S_READ:  state_q <= S_ACC;
        S_ACC:   state_q <= S_CHK;
        S_CHK:   state_q <= status_i.emit ? S_AMUL : S_ADV;
        S_AMUL:  state_q <= S_ADIV;
        S_ADIV:  state_q <= S_AWAIT;
        S_AWAIT: begin
          if (status_i.div_done) state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!status_i.out_busy) state_q <= S_ADV;
        end
        S_ADV: begin
          phase_q <= 1'b1;
          if (status_i.col_adv) state_q <= S_CMUL;
          else if (status_i.row_adv) state_q <= S_RMUL;
          else state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.op_sel = OP_COL;
    unique case (state_q)
      S_CLEAR: cmd_o.clr_en    = 1'b1;
      S_IDLE:  cmd_o.accept    = in_valid_i;
      S_START: cmd_o.start_pos = 1'b1;
      S_CMUL:  cmd_o.mul_en    = 1'b1;
      S_CDIV:  cmd_o.div_start = 1'b1;
      S_CWAIT: cmd_o.col_edge_ld = status_i.div_done;
      S_RMUL: begin
        cmd_o.op_sel = OP_ROW;
        cmd_o.mul_en = 1'b1;
      end
      S_RDIV: begin
        cmd_o.op_sel    = OP_ROW;
        cmd_o.div_start = 1'b1;
      end
      S_RWAIT: cmd_o.row_edge_ld = status_i.div_done;
      S_READ:  cmd_o.rd_en  = 1'b1;
      S_ACC:   cmd_o.acc_en = 1'b1;
      S_AMUL: begin
        cmd_o.op_sel = OP_AREA;
        cmd_o.mul_en = 1'b1;
      end
      S_ADIV: begin
        cmd_o.op_sel    = OP_AREA;
        cmd_o.div_start = 1'b1;
      end
      S_EMIT:  cmd_o.out_ld = !status_i.out_busy;
      S_ADV:   cmd_o.adv    = 1'b1;
      default: ;
    endcase
  end

  assign in_ready_o = state_q == S_IDLE;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q != S_IDLE)
    else $error("Controller stayed idle after taking a transaction.");
`endif

endmodule

// ----- rtl/area_average_downscaler.sv -----
// Area-average downscaler for a streamed RGB picture, pixels in raster order.
// The input channel (in_valid_i, in_ready_o, in_data_i) takes one source
// pixel per transaction; frame_start marks the first pixel of a frame. The
// output channel (out_valid_o, out_ready_i, out_data_o) delivers one averaged
// pixel whenever a source pixel closes a destination box.
// Configuration writes (cfg_valid_i, cfg_index_i, cfg_data_i) are always
// taken and must only arrive while the block is idle.
// One pixel is handled at a time. Each pixel is read, accumulated and checked;
// an edge division is added on every box boundary and at the start of each
// source row, and a pixel that closes a box adds the averaging division and
// the load of the result. The 32-step radix-2 divider is shared by every
// division.
// After reset, and after every pixel that carries frame_start, the sum
// memory is cleared over all MAX_TARGET_WIDTH entries, and no pixel is
// accepted during the pass. A result waits in the output register while the
// next pixel is accepted; only a second result stalls the block until the
// first transaction is taken.
module area_average_downscaler import aad_pkg::*; #(
  parameter int unsigned MAX_SOURCE_WIDTH  = 4096,
  parameter int unsigned MAX_SOURCE_HEIGHT = 4096,
  parameter int unsigned MAX_TARGET_WIDTH  = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pix_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pix_out_t              out_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  aad_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_frame_start_i (in_data_i.frame_start),
    .in_ready_o       (in_ready_o),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  aad_datapath #(
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
    .MAX_TARGET_WIDTH  (MAX_TARGET_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ----- verif/area_average_downscaler_tb.sv -----
`timescale 1ns / 1ps

module area_average_downscaler_tb;
  import aad_pkg::*;

  localparam int unsigned SRC_W_MAX = 4096;
  localparam int unsigned SRC_H_MAX = 4096;
  localparam int unsigned DST_W_MAX = 2048;
  localparam int unsigned SETTLE    = 300;
  localparam int unsigned LIMIT     = 4000000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_SOURCE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  pix_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  pix_out_t              out_data_o;

  area_average_downscaler dut (.*);

  always #2 clk_i = ~clk_i;

  pix_in_t  pixel_q[$];
  pix_out_t box_avg_q[$];
  bit       calm = 1'b0;
  int unsigned errors = 0, pixels_sent = 0, boxes_seen = 0, cycles = 0, setups = 0;

  // Shadow of the block's registers and accumulation state.
  int unsigned src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
  int unsigned red_acc[DST_W_MAX], grn_acc[DST_W_MAX], blu_acc[DST_W_MAX];
  int unsigned s_col, s_row, d_col, d_row, col_edge, row_edge, col_start, row_start;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [PIX_W-1:0] box_mean(int unsigned sum, int unsigned area);
    int unsigned q;
    q = sum / area;
    return (q > 255) ? 8'hff : q[7:0];
  endfunction

  function automatic void clear_sums();
    for (int i = 0; i < DST_W_MAX; i++) begin
      red_acc[i] = 0;
      grn_acc[i] = 0;
      blu_acc[i] = 0;
    end
  endfunction

  function automatic void accumulate_pixel(pix_in_t p);
    int unsigned sw, sh, dw, dh, wmax, w, h, area;
    bit row_end, last, col_end, rbox_end, in_mem;
    pix_out_t r;
    sw = clampu(src_w_reg, 1, SRC_W_MAX);
    sh = clampu(src_h_reg, 1, SRC_H_MAX);
    wmax = (sw < DST_W_MAX) ? sw : DST_W_MAX;
    dw = clampu(dst_w_reg, 1, wmax);
    dh = clampu(dst_h_reg, 1, sh);
    if (p.frame_start) begin
      s_col = 0;
      s_row = 0;
      clear_sums();
    end
    if (s_col == 0) begin
      d_col = 0;
      col_start = 0;
      col_edge = sw / dw;
      if (s_row == 0) begin
        d_row = 0;
        row_start = 0;
        row_edge = sh / dh;
      end
    end
    in_mem = d_col < DST_W_MAX;
    if (in_mem) begin
      red_acc[d_col] += p.red_in;
      grn_acc[d_col] += p.green_in;
      blu_acc[d_col] += p.blue_in;
    end
    row_end = s_col + 1 >= sw;
    last = row_end && (s_row + 1 >= sh);
    col_end = row_end || (s_col + 1 >= col_edge);
    rbox_end = last || (s_row + 1 >= row_edge);
    if (col_end && rbox_end) begin
      w = (s_col >= col_start) ? s_col + 1 - col_start : 1;
      h = (s_row >= row_start) ? s_row + 1 - row_start : 1;
      area = w * h;
      if (area == 0) area = 1;
      r = '0;
      if (in_mem) begin
        r.red_out = box_mean(red_acc[d_col], area);
        r.green_out = box_mean(grn_acc[d_col], area);
        r.blue_out = box_mean(blu_acc[d_col], area);
        red_acc[d_col] = 0;
        grn_acc[d_col] = 0;
        blu_acc[d_col] = 0;
      end
      r.out_column = d_col[DCOL_W-1:0];
      r.out_row = d_row[DROW_W-1:0];
      r.frame_end = last;
      box_avg_q.push_back(r);
    end
    if (last) begin
      s_col = 0;
      s_row = 0;
    end else if (row_end) begin
      s_col = 0;
      if (rbox_end) begin
        row_start = row_edge;
        if (d_row < DROW_MAX) d_row++;
        row_edge = (d_row + 1) * sh / dh;
      end
      s_row++;
    end else begin
      if (col_end) begin
        col_start = col_edge;
        if (d_col < DCOL_MAX) d_col++;
        col_edge = (d_col + 1) * sw / dw;
      end
      s_col++;
    end
  endfunction

  // Pixel driver.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        accumulate_pixel(in_data_i);
        pixels_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pixel_q.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
          in_data_i <= pixel_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    pix_out_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        boxes_seen++;
        if (box_avg_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction %h", $time, out_data_o);
        end else begin
          want = box_avg_q.pop_front();
          if (want.red_out !== out_data_o.red_out || want.green_out !== out_data_o.green_out ||
              want.blue_out !== out_data_o.blue_out ||
              want.out_column !== out_data_o.out_column ||
              want.out_row !== out_data_o.out_row || want.frame_end !== out_data_o.frame_end) begin
            errors++;
            $display("%0t: mismatch, expected %h, actual %h", $time, want, out_data_o);
          end
        end
      end
      out_ready_i <= calm || ($urandom_range(99) >= 33);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SOURCE_WIDTH:  src_w_reg = val & 13'h1fff;
      CFG_SOURCE_HEIGHT: src_h_reg = val & 13'h1fff;
      CFG_TARGET_WIDTH:  dst_w_reg = val & 12'hfff;
      CFG_TARGET_HEIGHT: dst_h_reg = val & 13'h1fff;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid_i || box_avg_q.size() != 0 || !in_ready_o)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh);
    wait_idle();
    write_reg(CFG_SOURCE_WIDTH, sw);
    write_reg(CFG_SOURCE_HEIGHT, sh);
    write_reg(CFG_TARGET_WIDTH, dw);
    write_reg(CFG_TARGET_HEIGHT, dh);
    setups++;
    calm = (setups % 4 == 1);
  endtask

  function automatic pix_in_t make_pixel(bit fs, int mode);
    pix_in_t p;
    p.frame_start = fs;
    case (mode)
      0: begin p.red_in = 8'h00; p.green_in = 8'h00; p.blue_in = 8'h00; end
      1: begin p.red_in = 8'hff; p.green_in = 8'hff; p.blue_in = 8'hff; end
      default: begin
        p.red_in = 8'($urandom);
        p.green_in = 8'($urandom);
        p.blue_in = 8'($urandom);
      end
    endcase
    return p;
  endfunction

  task automatic push_pixels(int unsigned n, bit first_fs, int mode);
    for (int unsigned i = 0; i < n; i++) pixel_q.push_back(make_pixel(first_fs && i == 0, mode));
  endtask

  initial begin
    int unsigned sw, sh, pushed, frame, frames;
    src_w_reg = 1; src_h_reg = 1; dst_w_reg = 1; dst_h_reg = 1;
    s_col = 0; s_row = 0; d_col = 0; d_row = 0;
    col_edge = 0; row_edge = 0; col_start = 0; row_start = 0;
    clear_sums();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_geometry(4, 2, 2, 1);
    push_pixels(8, 1, 1);
    set_geometry(3, 3, 2, 2);
    push_pixels(9, 1, 0);
    set_geometry(2, 1, 7, 9);
    push_pixels(2, 1, 2);
    set_geometry(0, 0, 0, 0);
    push_pixels(3, 0, 2);
    // Geometry changed part way through a frame.
    set_geometry(4, 2, 2, 1);
    push_pixels(3, 1, 2);
    set_geometry(2, 2, 2, 2);
    push_pixels(3, 0, 1);
    set_geometry(8191, 8191, 4095, 8191);
    push_pixels(4, 1, 1);
    pushed = 32;

    while (pushed < 600) begin
      sw = $urandom_range(12, 1);
      sh = $urandom_range(8, 1);
      set_geometry(sw, sh, $urandom_range(sw + 2, 1), $urandom_range(sh + 2, 1));
      frames = $urandom_range(3, 1);
      for (frame = 0; frame < frames; frame++) begin
        if ($urandom_range(99) < 15) begin
          push_pixels($urandom_range(sw * sh + 4, 1), 1'($urandom_range(1)), 2);
          pushed += 0;
        end else begin
          push_pixels(sw * sh, 1, ($urandom_range(9) == 0) ? $urandom_range(1) : 2);
          pushed += sw * sh;
        end
        if ($urandom_range(9) == 0) pixel_q.push_back(make_pixel(1'($urandom_range(1)), 2));
      end
    end
    wait_idle();

    $display("Covered %0d pixels and %0d averaged results over %0d geometries.",
             pixels_sent, boxes_seen, setups);
    $display("Mismatches found: %0d.", errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/aad_pkg.sv
rtl/aad_divider.sv
rtl/aad_datapath.sv
rtl/aad_ctrl.sv
rtl/area_average_downscaler.sv
verif/area_average_downscaler_tb.sv
